### src/dhms_pkg.sv
// Shared types and constants for the days/hours/minutes/seconds timer.
`timescale 1ns / 1ps

package dhms_pkg;

  localparam int DAY_W   = 16;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int TOTAL_W = 32;
  localparam int CMD_W   = 2;
  localparam int REST_W  = 17;

  // Number of register stages that split a loaded total into fields.
  localparam int PREP_STAGES = 7;

  localparam logic [SEC_W-1:0]   SECS_LAST  = 6'd59;
  localparam logic [MIN_W-1:0]   MINS_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0]  HOURS_LAST = 5'd23;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 32'hFFFF_FFFF;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Reciprocals for division by a constant: q = (n * RECIP) >> SHIFT.
  // Days: (total >> 7) / 675, with total >> 7 below 2**25.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int          DAY_SHIFT  = 35;
  // Hours: (rest >> 4) / 225, with rest >> 4 below 5400.
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam int          HOUR_SHIFT = 21;
  // Minutes: rest / 60, with rest below 3600.
  localparam logic [12:0] MIN_RECIP  = 13'd4370;
  localparam int          MIN_SHIFT  = 18;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_DOWN = 2'd1,
    CMD_UP   = 2'd2
  } cmd_t;

  // One request on its way through the load pipeline.
  typedef struct packed {
    cmd_t                cmd;
    logic [TOTAL_W-1:0]  total;
    logic [DAY_W-1:0]    days;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    secs;
    logic [REST_W-1:0]   rest;
  } prep_t;

endpackage

### src/dhms_in_if.sv
// Request channel of the timer: command and load value.
`timescale 1ns / 1ps

interface dhms_in_if;
  logic                          valid;
  logic                          ready;
  logic [dhms_pkg::CMD_W-1:0]    command;
  logic [dhms_pkg::TOTAL_W-1:0]  load_seconds;

  modport source (output valid, command, load_seconds, input ready);
  modport sink   (input valid, command, load_seconds, output ready);
endinterface

### src/dhms_out_if.sv
// Result channel of the timer: fields, total and status flags.
`timescale 1ns / 1ps

interface dhms_out_if;
  logic                          valid;
  logic                          ready;
  logic [dhms_pkg::DAY_W-1:0]    day_count;
  logic [dhms_pkg::HOUR_W-1:0]   hour_count;
  logic [dhms_pkg::MIN_W-1:0]    minute_count;
  logic [dhms_pkg::SEC_W-1:0]    second_count;
  logic [dhms_pkg::TOTAL_W-1:0]  total_count;
  logic                          is_zero;
  logic                          underflow_error;
  logic                          overflow_error;

  modport source (output valid, day_count, hour_count, minute_count, second_count,
                  total_count, is_zero, underflow_error, overflow_error,
                  input ready);
  modport sink   (input valid, day_count, hour_count, minute_count, second_count,
                  total_count, is_zero, underflow_error, overflow_error,
                  output ready);
endinterface

### src/dhms_up_down_timer.sv
// Days/hours/minutes/seconds up/down timer, top level.
//
// Requests arrive on in_chan (valid/ready). Each carries a command: load a
// seconds total, count down one second or count up one second. Every request
// gives exactly one result on out_chan, showing the day, hour, minute and
// second fields and the total after the step, a zero flag, and an underflow
// or overflow flag when a count was refused (state then stays as it was).
// A request passes seven register stages, where a loaded total is split into
// fields by reciprocal multiplication and subtraction, one narrow step per
// stage, and is applied to the timer state as it enters the output register.
// One request per cycle is taken for as long as results are taken.
// Each stage holds its request until the stage after it frees up, so when the
// receiver stalls, the stages fill up behind the waiting result and in_ready
// drops only once all of them are full.
// Reset clears the timer to zero and empties the pipeline.
`timescale 1ns / 1ps

module dhms_up_down_timer (
  input  logic              clk,
  input  logic              rst_n,
  dhms_in_if.sink           in_chan,
  dhms_out_if.source        out_chan
);

  localparam int NS = dhms_pkg::PREP_STAGES;

  dhms_pkg::prep_t                stg_r [1:NS];
  dhms_pkg::prep_t                stg_in [1:NS];
  logic [NS:1]                    v_r;
  logic [NS:1]                    v_in;
  logic [NS+1:1]                  can_load;

  logic [50:0]                    day_prod;
  logic [26:0]                    hour_prod;
  logic [24:0]                    min_prod;

  logic [dhms_pkg::TOTAL_W-1:0]   total_r, total_nxt;
  logic [dhms_pkg::DAY_W-1:0]     days_r, days_nxt;
  logic [dhms_pkg::HOUR_W-1:0]    hours_r, hours_nxt;
  logic [dhms_pkg::MIN_W-1:0]     minutes_r, minutes_nxt;
  logic [dhms_pkg::SEC_W-1:0]     secs_r, secs_nxt;
  logic                           under_r, under_nxt;
  logic                           over_r, over_nxt;
  logic                           out_valid_r;
  logic                           fields_zero;
  logic                           commit;

  // Handshake: a stage takes new content when it is empty or its own content
  // moves on in the same cycle.
  always_comb begin
    can_load[NS+1] = !out_valid_r || out_chan.ready;
    for (int k = NS; k >= 1; k--) begin
      can_load[k] = !v_r[k] || can_load[k+1];
    end
    v_in[1] = in_chan.valid;
    for (int k = 2; k <= NS; k++) begin
      v_in[k] = v_r[k-1];
    end
  end

  assign in_chan.ready = can_load[1];
  assign commit        = can_load[NS+1] && v_r[NS];

  // Split of a loaded total, one narrow step per stage.
  always_comb begin
    day_prod  = 51'(stg_r[1].total[31:7]) * 51'(dhms_pkg::DAY_RECIP);
    hour_prod = 27'(stg_r[3].rest[16:4]) * 27'(dhms_pkg::HOUR_RECIP);
    min_prod  = 25'(stg_r[5].rest[11:0]) * 25'(dhms_pkg::MIN_RECIP);

    stg_in[1]         = '0;
    stg_in[1].cmd     = dhms_pkg::cmd_t'(in_chan.command);
    stg_in[1].total   = in_chan.load_seconds;

    stg_in[2]         = stg_r[1];
    stg_in[2].days    = day_prod[dhms_pkg::DAY_SHIFT +: dhms_pkg::DAY_W];

    // The remainder is below one day, so its low bits are all that matter.
    stg_in[3]         = stg_r[2];
    stg_in[3].rest    = stg_r[2].total[16:0]
                        - 17'(stg_r[2].days * dhms_pkg::SECS_PER_DAY);

    stg_in[4]         = stg_r[3];
    stg_in[4].hours   = hour_prod[dhms_pkg::HOUR_SHIFT +: dhms_pkg::HOUR_W];

    stg_in[5]         = stg_r[4];
    stg_in[5].rest    = stg_r[4].rest
                        - (17'(stg_r[4].hours) * 17'(dhms_pkg::SECS_PER_HOUR));

    stg_in[6]         = stg_r[5];
    stg_in[6].minutes = min_prod[dhms_pkg::MIN_SHIFT +: dhms_pkg::MIN_W];

    stg_in[7]         = stg_r[6];
    stg_in[7].secs    = stg_r[6].rest[5:0]
                        - 6'(stg_r[6].minutes * dhms_pkg::SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (can_load[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NS; k++) begin
      if (can_load[k]) begin
        stg_r[k] <= stg_in[k];
      end
    end
  end

  assign fields_zero = (days_r == '0) && (hours_r == '0) && (minutes_r == '0)
                       && (secs_r == '0);

  // Timer state update for the request leaving the last stage.
  always_comb begin
    total_nxt   = total_r;
    days_nxt    = days_r;
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    secs_nxt    = secs_r;
    under_nxt   = 1'b0;
    over_nxt    = 1'b0;
    unique case (stg_r[NS].cmd)
      dhms_pkg::CMD_LOAD: begin
        total_nxt   = stg_r[NS].total;
        days_nxt    = stg_r[NS].days;
        hours_nxt   = stg_r[NS].hours;
        minutes_nxt = stg_r[NS].minutes;
        secs_nxt    = stg_r[NS].secs;
      end
      dhms_pkg::CMD_DOWN: begin
        if (fields_zero) begin
          under_nxt = 1'b1;
        end else begin
          total_nxt = total_r - 32'd1;
          if (secs_r != '0) begin
            secs_nxt = secs_r - 6'd1;
          end else if (minutes_r != '0) begin
            minutes_nxt = minutes_r - 6'd1;
            secs_nxt    = dhms_pkg::SECS_LAST;
          end else if (hours_r != '0) begin
            hours_nxt   = hours_r - 5'd1;
            minutes_nxt = dhms_pkg::MINS_LAST;
            secs_nxt    = dhms_pkg::SECS_LAST;
          end else begin
            days_nxt    = days_r - 16'd1;
            hours_nxt   = dhms_pkg::HOURS_LAST;
            minutes_nxt = dhms_pkg::MINS_LAST;
            secs_nxt    = dhms_pkg::SECS_LAST;
          end
        end
      end
      dhms_pkg::CMD_UP: begin
        if (total_r == dhms_pkg::TOTAL_MAX) begin
          over_nxt = 1'b1;
        end else begin
          total_nxt = total_r + 32'd1;
          if (secs_r < dhms_pkg::SECS_LAST) begin
            secs_nxt = secs_r + 6'd1;
          end else if (minutes_r < dhms_pkg::MINS_LAST) begin
            minutes_nxt = minutes_r + 6'd1;
            secs_nxt    = '0;
          end else if (hours_r < dhms_pkg::HOURS_LAST) begin
            hours_nxt   = hours_r + 5'd1;
            minutes_nxt = '0;
            secs_nxt    = '0;
          end else begin
            days_nxt    = days_r + 16'd1;
            hours_nxt   = '0;
            minutes_nxt = '0;
            secs_nxt    = '0;
          end
        end
      end
      default: begin
        // An unused command code leaves the state as it is.
        total_nxt = total_r;
      end
    endcase
  end

  // The state registers double as the result payload: they change only when
  // the result slot is free, so a waiting result always shows them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      days_r      <= '0;
      hours_r     <= '0;
      minutes_r   <= '0;
      secs_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        total_r   <= total_nxt;
        days_r    <= days_nxt;
        hours_r   <= hours_nxt;
        minutes_r <= minutes_nxt;
        secs_r    <= secs_nxt;
      end
      if (can_load[NS+1]) begin
        out_valid_r <= v_r[NS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      under_r <= under_nxt;
      over_r  <= over_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.day_count       = days_r;
  assign out_chan.hour_count      = hours_r;
  assign out_chan.minute_count    = minutes_r;
  assign out_chan.second_count    = secs_r;
  assign out_chan.total_count     = total_r;
  assign out_chan.is_zero         = fields_zero;
  assign out_chan.underflow_error = under_r;
  assign out_chan.overflow_error  = over_r;

endmodule

### src/dhms_checker.sv
// Port-level checks for the timer, attached to the top level by bind.
`timescale 1ns / 1ps

module dhms_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dhms_pkg::DAY_W-1:0]    day_count,
  input logic [dhms_pkg::HOUR_W-1:0]   hour_count,
  input logic [dhms_pkg::MIN_W-1:0]    minute_count,
  input logic [dhms_pkg::SEC_W-1:0]    second_count,
  input logic [dhms_pkg::TOTAL_W-1:0]  total_count,
  input logic                          is_zero,
  input logic                          underflow_error,
  input logic                          overflow_error
);

  // A stalled result stays offered and its total unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(total_count))
    else $error("result changed or dropped while stalled");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_zero == (day_count == '0 && hour_count == '0
                              && minute_count == '0 && second_count == '0))
    else $error("zero flag does not match the fields");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hour_count <= dhms_pkg::HOURS_LAST
                  && minute_count <= dhms_pkg::MINS_LAST
                  && second_count <= dhms_pkg::SECS_LAST)
    else $error("time field out of range");

  // A refused count-down leaves the timer at zero.
  a_under_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && underflow_error |-> is_zero && !overflow_error)
    else $error("underflow reported away from zero");

  // A refused count-up leaves the total at its largest value.
  a_over_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && overflow_error |-> total_count == dhms_pkg::TOTAL_MAX)
    else $error("overflow reported below the largest total");

endmodule

bind dhms_up_down_timer dhms_checker u_dhms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .day_count       (out_chan.day_count),
  .hour_count      (out_chan.hour_count),
  .minute_count    (out_chan.minute_count),
  .second_count    (out_chan.second_count),
  .total_count     (out_chan.total_count),
  .is_zero         (out_chan.is_zero),
  .underflow_error (out_chan.underflow_error),
  .overflow_error  (out_chan.overflow_error)
);

### tb/sv/dhms_up_down_timer_tb.sv
// Testbench for the days/hours/minutes/seconds up/down timer with a built-in predictor.
`timescale 1ns / 1ps

module dhms_up_down_timer_tb;

  // Unused code, leaves the timer alone.
  localparam logic [dhms_pkg::CMD_W-1:0] CMD_IDLE = 2'd3;
  localparam int ITEM_TARGET = 1550;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_STALL = 60;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic                           drain_first;
    logic [dhms_pkg::CMD_W-1:0]     code;
    logic [dhms_pkg::TOTAL_W-1:0]   load;
  } timer_req_t;

  typedef struct packed {
    logic [dhms_pkg::DAY_W-1:0]     days;
    logic [dhms_pkg::HOUR_W-1:0]    hours;
    logic [dhms_pkg::MIN_W-1:0]     mins;
    logic [dhms_pkg::SEC_W-1:0]     secs;
    logic [dhms_pkg::TOTAL_W-1:0]   total;
    logic                           zero;
    logic                           under;
    logic                           over;
  } timer_view_t;

  typedef struct packed {
    logic [dhms_pkg::TOTAL_W-1:0]   total;
    logic [dhms_pkg::DAY_W-1:0]     days;
    logic [dhms_pkg::HOUR_W-1:0]    hours;
    logic [dhms_pkg::MIN_W-1:0]     mins;
    logic [dhms_pkg::SEC_W-1:0]     secs;
  } timer_state_t;

  logic clk;
  logic rst_n;

  dhms_in_if  in_ch ();
  dhms_out_if out_ch ();

  dhms_up_down_timer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  timer_req_t   req_queue[$];
  timer_view_t  timer_views[$];
  timer_state_t clock_state = '0;

  int  err_count = 0;
  int  req_count = 0;
  int  cycle_count = 0;
  bit  req_taken = 1'b0;
  int  gap_left = 0;
  int  burst_left = 1;
  int  stall_left = 0;
  bit  long_stall_done = 1'b0;
  int  ready_mode = 0;
  int  mode_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic fields_clear();
    return clock_state.days == '0 && clock_state.hours == '0 &&
           clock_state.mins == '0 && clock_state.secs == '0;
  endfunction

  // Applies one request to the predicted timer and returns the view it should show.
  function automatic timer_view_t advance_timer(logic [dhms_pkg::CMD_W-1:0] code,
                                                logic [dhms_pkg::TOTAL_W-1:0] load);
    timer_view_t view;
    logic [dhms_pkg::TOTAL_W-1:0] rest;
    view = '0;
    case (code)
      dhms_pkg::CMD_LOAD: begin
        clock_state.total = load;
        clock_state.days  = dhms_pkg::DAY_W'(load / dhms_pkg::SECS_PER_DAY);
        rest = load % dhms_pkg::SECS_PER_DAY;
        clock_state.hours = dhms_pkg::HOUR_W'(rest / dhms_pkg::SECS_PER_HOUR);
        rest = rest % dhms_pkg::SECS_PER_HOUR;
        clock_state.mins  = dhms_pkg::MIN_W'(rest / dhms_pkg::SECS_PER_MIN);
        clock_state.secs  = dhms_pkg::SEC_W'(rest % dhms_pkg::SECS_PER_MIN);
      end
      dhms_pkg::CMD_DOWN: begin
        if (fields_clear()) begin
          view.under = 1'b1;
        end else begin
          clock_state.total = clock_state.total - 32'd1;
          if (clock_state.secs != '0) begin
            clock_state.secs = clock_state.secs - 6'd1;
          end else if (clock_state.mins != '0) begin
            clock_state.mins = clock_state.mins - 6'd1;
            clock_state.secs = dhms_pkg::SECS_LAST;
          end else if (clock_state.hours != '0) begin
            clock_state.hours = clock_state.hours - 5'd1;
            clock_state.mins  = dhms_pkg::MINS_LAST;
            clock_state.secs  = dhms_pkg::SECS_LAST;
          end else begin
            clock_state.days  = clock_state.days - 16'd1;
            clock_state.hours = dhms_pkg::HOURS_LAST;
            clock_state.mins  = dhms_pkg::MINS_LAST;
            clock_state.secs  = dhms_pkg::SECS_LAST;
          end
        end
      end
      dhms_pkg::CMD_UP: begin
        if (clock_state.total == dhms_pkg::TOTAL_MAX) begin
          view.over = 1'b1;
        end else begin
          clock_state.total = clock_state.total + 32'd1;
          if (clock_state.secs < dhms_pkg::SECS_LAST) begin
            clock_state.secs = clock_state.secs + 6'd1;
          end else if (clock_state.mins < dhms_pkg::MINS_LAST) begin
            clock_state.mins = clock_state.mins + 6'd1;
            clock_state.secs = '0;
          end else if (clock_state.hours < dhms_pkg::HOURS_LAST) begin
            clock_state.hours = clock_state.hours + 5'd1;
            clock_state.mins  = '0;
            clock_state.secs  = '0;
          end else begin
            clock_state.days  = clock_state.days + 16'd1;
            clock_state.hours = '0;
            clock_state.mins  = '0;
            clock_state.secs  = '0;
          end
        end
      end
      default: ;
    endcase
    view.days  = clock_state.days;
    view.hours = clock_state.hours;
    view.mins  = clock_state.mins;
    view.secs  = clock_state.secs;
    view.total = clock_state.total;
    view.zero  = fields_clear();
    return view;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic compare_view(timer_view_t got, timer_view_t want);
    if (got.days !== want.days)
      report_mismatch("day_count", 32'(got.days), 32'(want.days));
    if (got.hours !== want.hours)
      report_mismatch("hour_count", 32'(got.hours), 32'(want.hours));
    if (got.mins !== want.mins)
      report_mismatch("minute_count", 32'(got.mins), 32'(want.mins));
    if (got.secs !== want.secs)
      report_mismatch("second_count", 32'(got.secs), 32'(want.secs));
    if (got.total !== want.total)
      report_mismatch("total_count", got.total, want.total);
    if (got.zero !== want.zero)
      report_mismatch("is_zero", 32'(got.zero), 32'(want.zero));
    if (got.under !== want.under)
      report_mismatch("underflow_error", 32'(got.under), 32'(want.under));
    if (got.over !== want.over)
      report_mismatch("overflow_error", 32'(got.over), 32'(want.over));
  endtask

  task automatic queue_item(logic [dhms_pkg::CMD_W-1:0] code,
                            logic [dhms_pkg::TOTAL_W-1:0] load);
    timer_req_t item;
    item.drain_first = 1'b0;
    item.code = code;
    item.load = load;
    req_queue.push_back(item);
  endtask

  // Result side first, then the request taken at this edge: the result always
  // belongs to an older request.
  always @(posedge clk) begin : watch
    timer_view_t got;
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.days  = out_ch.day_count;
        got.hours = out_ch.hour_count;
        got.mins  = out_ch.minute_count;
        got.secs  = out_ch.second_count;
        got.total = out_ch.total_count;
        got.zero  = out_ch.is_zero;
        got.under = out_ch.underflow_error;
        got.over  = out_ch.overflow_error;
        if (timer_views.size() == 0)
          report_mismatch("result with nothing pending, total_count", got.total, 0);
        else
          compare_view(got, timer_views.pop_front());
      end
      req_taken = in_ch.valid && in_ch.ready;
      if (req_taken) begin
        timer_views.push_back(advance_timer(in_ch.command, in_ch.load_seconds));
        req_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("dhms_up_down_timer_tb: errors");
      $finish;
    end
  end

  // Request driver: bursts of requests with random gaps between them.
  always @(negedge clk) begin : drive
    timer_req_t item;
    if (rst_n && (!in_ch.valid || req_taken)) begin
      if (gap_left != 0 && stall_left == 0) begin
        in_ch.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (req_queue.size() == 0 ||
                   (req_queue[0].drain_first && timer_views.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else begin
        item = req_queue.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.command      <= item.code;
        in_ch.load_seconds <= item.load;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: changes its stall pattern at random intervals, and
  // once holds off long enough for the pipeline to back up to the input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!long_stall_done && req_count >= 700) begin
        out_ch.ready <= 1'b0;
        stall_left <= LONG_STALL;
        long_stall_done <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          ready_mode <= $urandom_range(0, 3);
          mode_left  <= $urandom_range(10, 80);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (ready_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 2) == 0);
          default: out_ch.ready <= (mode_left % 4 != 0);
        endcase
      end
    end
  end

  initial begin
    longint unsigned base;
    longint signed near;
    int run_len;
    int run_style;
    int first_random;
    timer_req_t item;
    logic [dhms_pkg::CMD_W-1:0] code;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = dhms_pkg::CMD_LOAD;
    in_ch.load_seconds = '0;
    out_ch.ready = 1'b0;

    // Directed part: fresh state, refusals, every carry and borrow, extremes.
    queue_item(CMD_IDLE, 32'hFFFF_FFFF);
    queue_item(dhms_pkg::CMD_DOWN, 32'h0000_0000);
    queue_item(dhms_pkg::CMD_UP, 32'h1234_5678);
    queue_item(dhms_pkg::CMD_DOWN, 32'hFFFF_FFFF);
    queue_item(dhms_pkg::CMD_DOWN, 32'h0);
    queue_item(dhms_pkg::CMD_LOAD, 32'd59);
    queue_item(dhms_pkg::CMD_UP, 32'h0);
    queue_item(dhms_pkg::CMD_DOWN, 32'h0);
    queue_item(dhms_pkg::CMD_LOAD, 32'd3599);
    queue_item(dhms_pkg::CMD_UP, 32'h0);
    queue_item(dhms_pkg::CMD_DOWN, 32'h0);
    queue_item(dhms_pkg::CMD_LOAD, 32'd86399);
    queue_item(dhms_pkg::CMD_UP, 32'h0);
    queue_item(dhms_pkg::CMD_DOWN, 32'h0);
    queue_item(dhms_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    queue_item(dhms_pkg::CMD_UP, 32'h0);
    queue_item(dhms_pkg::CMD_DOWN, 32'h0);
    queue_item(dhms_pkg::CMD_UP, 32'h0);
    queue_item(CMD_IDLE, 32'h0);
    queue_item(dhms_pkg::CMD_LOAD, 32'hAAAA_AAAA);
    queue_item(dhms_pkg::CMD_LOAD, 32'h5555_5555);
    queue_item(dhms_pkg::CMD_LOAD, 32'd1);
    queue_item(dhms_pkg::CMD_DOWN, 32'hAAAA_AAAA);
    queue_item(dhms_pkg::CMD_DOWN, 32'h5555_5555);
    queue_item(dhms_pkg::CMD_LOAD, 32'd0);
    first_random = req_queue.size();

    // Random part: a load, often close to a field boundary, then a run of counts.
    while (req_queue.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2: near = longint'($urandom);
        3: near = longint'($urandom_range(0, 49710)) * 86400 +
                  longint'($urandom_range(0, 6)) - 3;
        4: near = longint'($urandom_range(0, 1193046)) * 3600 +
                  longint'($urandom_range(0, 6)) - 3;
        5: near = longint'($urandom) / 60 * 60 + longint'($urandom_range(0, 6)) - 3;
        6: near = 64'h0000_0000_FFFF_FFFF - longint'($urandom_range(0, 8));
        7: near = longint'($urandom_range(0, 8));
        default: near = longint'($urandom);
      endcase
      if (near < 0) near = 0;
      base = (near > 64'h0000_0000_FFFF_FFFF) ? 64'h0000_0000_FFFF_FFFF : near;
      queue_item(dhms_pkg::CMD_LOAD, base[dhms_pkg::TOTAL_W-1:0]);
      run_len = $urandom_range(1, 14);
      run_style = $urandom_range(0, 3);
      repeat (run_len) begin
        case (run_style)
          0: code = dhms_pkg::CMD_UP;
          1: code = dhms_pkg::CMD_DOWN;
          2: code = $urandom_range(0, 1) ? dhms_pkg::CMD_UP : dhms_pkg::CMD_DOWN;
          default: code = ($urandom_range(0, 4) != 0) ? dhms_pkg::CMD_DOWN
                                                       : dhms_pkg::CMD_UP;
        endcase
        if ($urandom_range(0, 19) == 0) code = CMD_IDLE;
        else if ($urandom_range(0, 39) == 0) code = dhms_pkg::CMD_LOAD;
        queue_item(code, $urandom);
      end
    end

    // Two points where the sender waits for every result before going on.
    item = req_queue[first_random];
    item.drain_first = 1'b1;
    req_queue[first_random] = item;
    item = req_queue[900];
    item.drain_first = 1'b1;
    req_queue[900] = item;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_ch.valid) @(negedge clk);
    while (timer_views.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("dhms_up_down_timer_tb: clean");
    end else begin
      $display("dhms_up_down_timer_tb: errors");
    end
    $finish;
  end

endmodule

### files.f
src/dhms_pkg.sv
src/dhms_in_if.sv
src/dhms_out_if.sv
src/dhms_up_down_timer.sv
src/dhms_checker.sv
tb/sv/dhms_up_down_timer_tb.sv
